// ===== src/fpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
package fpr_pkg;

  // Frame delimiters
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Header length in bytes after STX
  localparam logic [3:0] HDR_BYTES = 4'd9;

  // Reset value of the length limit
  localparam logic [15:0] MAX_LEN_RESET = 16'd25600;

  // Register byte addresses
  localparam logic [2:0] ADDR_MAX_LEN = 3'd0;

  // Input word kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Result word kinds
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_RECORD  = 1'b1;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_GOOD     = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_NO_ETX   = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_ABORTED  = 3'd4
  } status_e;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_HEADER   = 5'b00010,
    PH_PAYLOAD  = 5'b00100,
    PH_CHECKSUM = 5'b01000,
    PH_ETX      = 5'b10000
  } phase_e;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    status_e     frame_status;
    logic [15:0] payload_length;
    logic [7:0]  command_minor;
    logic [7:0]  command_major;
    logic [31:0] dest_id;
    logic [7:0]  unit_type;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

// ===== src/framed_packet_receiver.sv =====
// Byte-serial STX/ETX frame parser with additive checksum and end-of-frame records.
// A result word is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the output drains; the state update and result
// selection sit between the input handshake and a single output register that decouples
// the two sides. Reset: asynchronous, active low; parser returns to STX search, held
// header cleared, length limit set to 25600, output register empty.
module framed_packet_receiver
  import fpr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic          s_axis_tuser,   // [0] kind
  // Result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] unit_type,
  // [63:32] dest_id, [71:64] command_major, [79:72] command_minor,
  // [95:80] payload_length, [98:96] frame_status, [103:99] zero
  output logic [103:0]  m_axis_tdata,
  output logic          m_axis_tuser,   // [0] result_kind
  // Configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration register
  logic [15:0] max_len_q;
  logic        cfg_wr;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  device_q, device_d;
  logic [31:0] target_q, target_d;
  logic [7:0]  cmd_major_q, cmd_major_d;
  logic [7:0]  cmd_minor_q, cmd_minor_d;
  logic [15:0] length_q, length_d;
  logic [15:0] position_q, position_d;
  logic [7:0]  sum_q, sum_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic        out_kind_q;
  result_t     out_q;

  logic        in_accept;
  logic        res_valid;
  logic        res_kind;
  result_t     res;
  logic [3:0]  cnt_next;
  logic [15:0] len_full;
  logic [15:0] pos_next;
  logic        clear;
  logic        flush;
  logic [7:0]  rx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_LEN[2]);
  assign prdata = (paddr[2] == ADDR_MAX_LEN[2]) ? {16'd0, max_len_q} : 32'd0;

  // Write the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_q <= pwdata[15:0];
    end
  end

  // Take a new word whenever the output register is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign flush    = (s_axis_tuser == KIND_FLUSH);
  assign rx       = s_axis_tdata;
  assign cnt_next = hdr_cnt_q + 4'd1;
  assign len_full = {length_q[15:8], rx};
  assign pos_next = position_q + 16'd1;

  // Next state and result word for the offered byte
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    device_d    = device_q;
    target_d    = target_q;
    cmd_major_d = cmd_major_q;
    cmd_minor_d = cmd_minor_q;
    length_d    = length_q;
    position_d  = position_q;
    sum_d       = sum_q;
    clear       = 1'b0;
    res_valid   = 1'b0;
    res_kind    = RES_RECORD;

    res.pad            = '0;
    res.frame_status   = ST_GOOD;
    res.payload_length = length_q;
    res.command_minor  = cmd_minor_q;
    res.command_major  = cmd_major_q;
    res.dest_id        = target_q;
    res.unit_type      = device_q;
    res.payload_index  = position_q;
    res.payload_byte   = 8'd0;

    if (flush) begin
      // Abort any open frame
      clear = 1'b1;
      if (phase_q == PH_HEADER || phase_q == PH_PAYLOAD ||
          phase_q == PH_CHECKSUM || phase_q == PH_ETX) begin
        res_valid        = 1'b1;
        res.frame_status = ST_ABORTED;
      end
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          hdr_cnt_d = cnt_next;
          sum_d     = sum_q + rx;
          case (cnt_next) inside
            4'd1:          device_d    = rx;
            [4'd2:4'd5]:   target_d    = {target_q[23:0], rx};
            4'd6:          cmd_major_d = rx;
            4'd7:          cmd_minor_d = rx;
            4'd8:          length_d    = {rx, 8'd0};
            default: begin
              length_d = len_full;
              if (len_full > max_len_q) begin
                res_valid          = 1'b1;
                res.payload_length = len_full;
                res.frame_status   = ST_TOO_LONG;
                clear              = 1'b1;
              end else begin
                position_d = 16'd0;
                phase_d    = (len_full != 16'd0) ? PH_PAYLOAD : PH_CHECKSUM;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res_kind         = RES_PAYLOAD;
          res.payload_byte = rx;
          sum_d            = sum_q + rx;
          position_d       = pos_next;
          if (pos_next >= length_q) begin
            phase_d = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          if (sum_q != rx) begin
            res_valid        = 1'b1;
            res.frame_status = ST_CHECKSUM;
            clear            = 1'b1;
          end else begin
            phase_d = PH_ETX;
          end
        end
        PH_ETX: begin
          res_valid        = 1'b1;
          res.frame_status = (rx == ETX_BYTE) ? ST_GOOD : ST_NO_ETX;
          clear            = 1'b1;
        end
        default: begin
          // Search for STX; unused codes fall here too
          clear = 1'b1;
          if (rx == STX_BYTE) begin
            clear   = 1'b0;
            phase_d = PH_HEADER;
            hdr_cnt_d   = 4'd0;
            device_d    = 8'd0;
            target_d    = 32'd0;
            cmd_major_d = 8'd0;
            cmd_minor_d = 8'd0;
            length_d    = 16'd0;
            position_d  = 16'd0;
            sum_d       = STX_BYTE;
          end
        end
      endcase
    end

    // Drop the frame context after a record or in STX search
    if (clear) begin
      phase_d     = PH_IDLE;
      hdr_cnt_d   = 4'd0;
      device_d    = 8'd0;
      target_d    = 32'd0;
      cmd_major_d = 8'd0;
      cmd_minor_d = 8'd0;
      length_d    = 16'd0;
      position_d  = 16'd0;
      sum_d       = 8'd0;
    end
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_cnt_q   <= 4'd0;
      device_q    <= 8'd0;
      target_q    <= 32'd0;
      cmd_major_q <= 8'd0;
      cmd_minor_q <= 8'd0;
      length_q    <= 16'd0;
      position_q  <= 16'd0;
      sum_q       <= 8'd0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      device_q    <= device_d;
      target_q    <= target_d;
      cmd_major_q <= cmd_major_d;
      cmd_minor_q <= cmd_minor_d;
      length_q    <= length_d;
      position_q  <= position_d;
      sum_q       <= sum_d;
    end
  end

  // Hold a result until taken; load a new one as the old one drains
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (in_accept) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      out_kind_q <= res_kind;
      out_q      <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_q;

  // A record always leaves the parser in STX search with a clean sum
  a_record_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid && res_kind == RES_RECORD) |=>
      (phase_q == PH_IDLE && sum_q == 8'd0 && position_q == 16'd0))
    else $error("frame context not cleared after record");

  // Payload position stays below the declared length while in payload
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (position_q < length_q))
    else $error("payload position beyond declared length");

  // Header count never runs past the header
  a_hdr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HDR_BYTES)
    else $error("header count overrun");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !in_accept)
    else $error("input accepted while result stalled");

endmodule

// ===== bench/framed_packet_receiver_tb.sv =====
// Self-checking testbench for the STX/ETX framed packet receiver.
`timescale 1ns / 100ps

module framed_packet_receiver_tb
  import fpr_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;

  // One received word as the sender presents it
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_item_t;

  // One result word as the parser should produce it
  typedef struct packed {
    logic    kind;
    result_t data;
  } expected_word_t;

  // Ways a generated frame is damaged
  typedef enum int {DEF_NONE, DEF_SUM, DEF_ETX, DEF_FLUSH} defect_e;

  // Frame parser mirror plus the queue of result words it predicts
  class frame_scoreboard;
    phase_e         ph;
    logic [3:0]     hdr_cnt;
    logic [7:0]     dev;
    logic [31:0]    tgt;
    logic [7:0]     cmaj;
    logic [7:0]     cmin;
    logic [15:0]    len;
    logic [15:0]    pos;
    logic [7:0]     sum;
    logic [15:0]    max_len;
    expected_word_t exp_q[$];
    int unsigned    errors;

    function new();
      max_len = MAX_LEN_RESET;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph      = PH_IDLE;
      hdr_cnt = '0;
      dev     = '0;
      tgt     = '0;
      cmaj    = '0;
      cmin    = '0;
      len     = '0;
      pos     = '0;
      sum     = '0;
    endfunction

    function int unsigned pending();
      return exp_q.size();
    endfunction

    function void push_word(logic k, logic [7:0] b, status_e st);
      expected_word_t e;
      e.kind                = k;
      e.data                = '0;
      e.data.payload_byte   = b;
      e.data.payload_index  = pos;
      e.data.unit_type      = dev;
      e.data.dest_id        = tgt;
      e.data.command_major  = cmaj;
      e.data.command_minor  = cmin;
      e.data.payload_length = len;
      e.data.frame_status   = st;
      exp_q.push_back(e);
    endfunction

    // Emit the end-of-frame record and drop back to STX search
    function void close_frame(status_e st);
      push_word(RES_RECORD, 8'h00, st);
      clear_frame();
    endfunction

    // Advance the mirror by one accepted input word
    function void note_word(logic kind, logic [7:0] b);
      if (kind == KIND_FLUSH) begin
        if (ph != PH_IDLE) close_frame(ST_ABORTED);
        else clear_frame();
        return;
      end
      case (ph)
        PH_HEADER: begin
          hdr_cnt = hdr_cnt + 4'd1;
          sum     = sum + b;
          case (hdr_cnt) inside
            4'd1:        dev  = b;
            [4'd2:4'd5]: tgt  = {tgt[23:0], b};
            4'd6:        cmaj = b;
            4'd7:        cmin = b;
            4'd8:        len  = {b, 8'h00};
            default: begin
              len = len | {8'h00, b};
              if (len > max_len) begin
                close_frame(ST_TOO_LONG);
              end else begin
                pos = '0;
                ph  = (len != 16'd0) ? PH_PAYLOAD : PH_CHECKSUM;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          push_word(RES_PAYLOAD, b, ST_GOOD);
          sum = sum + b;
          pos = pos + 16'd1;
          if (pos >= len) ph = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          if (sum != b) close_frame(ST_CHECKSUM);
          else ph = PH_ETX;
        end
        PH_ETX: close_frame((b == ETX_BYTE) ? ST_GOOD : ST_NO_ETX);
        default: begin
          if (b == STX_BYTE) begin
            clear_frame();
            ph  = PH_HEADER;
            sum = STX_BYTE;
          end else begin
            ph = PH_IDLE;
          end
        end
      endcase
    endfunction

    function string describe(logic k, result_t r);
      return $sformatf({"kind %0d byte %02h idx %0d dev %02h tgt %08h",
                        " cmd %02h/%02h len %0d st %0d"},
                       k, r.payload_byte, r.payload_index, r.unit_type, r.dest_id,
                       r.command_major, r.command_minor, r.payload_length, r.frame_status);
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_word(logic kind, result_t act);
      expected_word_t e;
      bit             bad;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", describe(kind, act));
        return;
      end
      e   = exp_q.pop_front();
      bad = 1'b0;
      if (kind !== e.kind) bad = 1'b1;
      if (act.payload_byte !== e.data.payload_byte) bad = 1'b1;
      if (act.payload_index !== e.data.payload_index) bad = 1'b1;
      if (act.unit_type !== e.data.unit_type) bad = 1'b1;
      if (act.dest_id !== e.data.dest_id) bad = 1'b1;
      if (act.command_major !== e.data.command_major) bad = 1'b1;
      if (act.command_minor !== e.data.command_minor) bad = 1'b1;
      if (act.payload_length !== e.data.payload_length) bad = 1'b1;
      if (act.frame_status !== e.data.frame_status) bad = 1'b1;
      if (act.pad !== 5'd0) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %s", describe(e.kind, e.data));
          $display("          actual   %s", describe(kind, act));
        end
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  frame_scoreboard sb;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     words_sent     = 0;
  int unsigned     cycle_count    = 0;

  framed_packet_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch both handshakes and drive the result-side backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Present one word, idling at random first, and hold it until accepted
  task automatic send_word(logic kind, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Hold off the sender until every predicted word has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the length limit through the register port
  task automatic write_max_len(logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_LEN;
    pwdata  <= {16'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.max_len = v;
  endtask

  // Mostly short payloads, with the limit boundary and full-range lengths now and then
  function automatic logic [15:0] pick_len();
    int unsigned r;
    logic [15:0] lim;
    r   = $urandom_range(99);
    lim = sb.max_len;
    if (r < 70) return 16'($urandom_range(0, 12));
    if (r < 80) return lim;
    if (r < 90) return (lim == 16'hFFFF) ? lim : lim + 16'd1;
    return 16'($urandom);
  endfunction

  // Build one frame, damage it as asked, and send it
  task automatic send_frame(defect_e d, logic [15:0] len, bit fixed, logic [7:0] fill);
    rx_item_t    fq[$];
    logic [7:0]  hdr[9];
    logic [7:0]  s;
    logic [7:0]  b;
    int unsigned n;
    int unsigned cut;
    defect_e     dd;
    dd = d;
    for (int i = 0; i < 7; i++) hdr[i] = fixed ? fill : 8'($urandom);
    hdr[7] = len[15:8];
    hdr[8] = len[7:0];
    fq.push_back({KIND_DATA, STX_BYTE});
    s = STX_BYTE;
    for (int i = 0; i < 9; i++) begin
      fq.push_back({KIND_DATA, hdr[i]});
      s = s + hdr[i];
    end
    // Long accepted payloads are cut short by a flush
    if (len <= sb.max_len) begin
      n = (len > 16'd64) ? 60 : int'(len);
      if (len > 16'd64) dd = DEF_FLUSH;
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        fq.push_back({KIND_DATA, b});
        s = s + b;
      end
      case (dd)
        DEF_SUM: begin
          fq.push_back({KIND_DATA, 8'(s + $urandom_range(1, 255))});
          fq.push_back({KIND_DATA, ETX_BYTE});
        end
        DEF_ETX: begin
          b = 8'($urandom);
          if (b == ETX_BYTE) b = ~b;
          fq.push_back({KIND_DATA, s});
          fq.push_back({KIND_DATA, b});
        end
        default: begin
          fq.push_back({KIND_DATA, s});
          fq.push_back({KIND_DATA, ETX_BYTE});
        end
      endcase
    end
    if (dd == DEF_FLUSH) begin
      cut = $urandom_range(1, fq.size() - 1);
      while (fq.size() > cut) fq.delete(fq.size() - 1);
      fq.push_back({KIND_FLUSH, 8'($urandom)});
    end
    foreach (fq[i]) send_word(fq[i].kind, fq[i].data);
  endtask

  // Random traffic: mostly frames, some line noise and stray flushes
  task automatic run_traffic(int unsigned count);
    int unsigned stop;
    int unsigned r;
    int unsigned k;
    defect_e     d;
    stop = words_sent + count;
    while (words_sent < stop) begin
      r = $urandom_range(99);
      if (r < 75) begin
        k = $urandom_range(99);
        if (k < 45) d = DEF_NONE;
        else if (k < 60) d = DEF_SUM;
        else if (k < 75) d = DEF_ETX;
        else d = DEF_FLUSH;
        send_frame(d, pick_len(), 1'b0, 8'h00);
      end else if (r < 90) begin
        k = $urandom_range(1, 4);
        repeat (k) send_word(KIND_DATA, 8'($urandom));
      end else begin
        send_word(KIND_FLUSH, 8'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flush while idle, a stray byte, an empty frame and an oversized one
    send_word(KIND_FLUSH, 8'h00);
    send_word(KIND_DATA, 8'hFF);
    send_frame(DEF_NONE, 16'h0000, 1'b1, 8'hFF);
    send_frame(DEF_NONE, 16'hFFFF, 1'b1, 8'h00);

    // Random phases, each with its own idling and length limit
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 0;
          write_max_len(16'h0000);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 54;
          write_max_len(16'hFFFF);
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
          write_max_len(16'($urandom_range(1, 16)));
        end
      endcase
      run_traffic(125);
      wait_idle();
      run_traffic(125);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fpr_pkg.sv
src/framed_packet_receiver.sv
bench/framed_packet_receiver_tb.sv
